// File: rtl/rcsd_pkg.sv
// shared constants and types for the rns crt signed digit decomposition unit
`timescale 1ns / 1ps
package rcsd_pkg;

   localparam int DIGIT_BITS = 16;
   localparam int DIGITS     = 4;

   localparam int WORD_W  = 32;
   localparam int WIDE_W  = 64;
   localparam int DNUM_W  = 4;
   localparam int STEP_W  = 7;
   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_MODULUS_A   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MODULUS_B   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_INV_B_MOD_A = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_INV_A_MOD_B = 2'd3;

   typedef struct packed {
      logic [WORD_W-1:0] modulus_a;
      logic [WORD_W-1:0] modulus_b;
      logic [WORD_W-1:0] inv_b_mod_a;
      logic [WORD_W-1:0] inv_a_mod_b;
   } cfg_type;

endpackage

// File: rtl/rcsd_modu.sv
// bit-serial remainder unit: 64-bit top-aligned dividend modulo a 32-bit modulus
`timescale 1ns / 1ps
module rcsd_modu (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [rcsd_pkg::WIDE_W-1:0]   dividend,
   input  logic [rcsd_pkg::STEP_W-1:0]   steps,
   input  logic [rcsd_pkg::WORD_W-1:0]   modulus,
   output logic                          busy,
   output logic [rcsd_pkg::WORD_W-1:0]   result
);

   logic                          busy_ff, busy_in;
   logic [rcsd_pkg::STEP_W-1:0]   cnt_ff, cnt_in;
   logic [rcsd_pkg::WIDE_W-1:0]   div_ff, div_in;
   logic [rcsd_pkg::WORD_W-1:0]   rem_ff, rem_in;
   logic [rcsd_pkg::WORD_W:0]     rem_ext;
   logic [rcsd_pkg::WORD_W:0]     rem_sub;

   assign rem_ext = {rem_ff, div_ff[rcsd_pkg::WIDE_W-1]};
   assign rem_sub = rem_ext - {1'b0, modulus};

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      div_in  = div_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = steps;
         div_in  = dividend;
         rem_in  = '0;
      end else if (busy_ff) begin
         div_in = {div_ff[rcsd_pkg::WIDE_W-2:0], 1'b0};
         rem_in = (rem_ext >= {1'b0, modulus}) ? rem_sub[rcsd_pkg::WORD_W-1:0]
                                              : rem_ext[rcsd_pkg::WORD_W-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == rcsd_pkg::STEP_W'(1)) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      div_ff <= div_in;
      rem_ff <= rem_in;
   end

   assign busy   = busy_ff;
   assign result = rem_ff;

endmodule

// File: rtl/rcsd_front.sv
// front end: input buffer, crt lift and centering of one coefficient
`timescale 1ns / 1ps
module rcsd_front (
   input  logic                          clock,
   input  logic                          reset,
   input  rcsd_pkg::cfg_type             cfg,
   input  logic                          req_push,
   output logic                          req_full,
   input  logic [rcsd_pkg::WORD_W-1:0]   req_residue_a,
   input  logic [rcsd_pkg::WORD_W-1:0]   req_residue_b,
   output logic                          q_push,
   input  logic                          q_full,
   output logic [rcsd_pkg::WIDE_W-1:0]   q_data
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_STRT = 3'd1;
   localparam logic [2:0] ST_MODW = 3'd2;
   localparam logic [2:0] ST_PROD = 3'd3;
   localparam logic [2:0] ST_ADD1 = 3'd4;
   localparam logic [2:0] ST_ADD2 = 3'd5;
   localparam logic [2:0] ST_CTR  = 3'd6;
   localparam logic [2:0] ST_PUSH = 3'd7;

   logic [2:0]                    state_ff, state_in;
   logic                          buf_valid_ff, buf_valid_in;
   logic [rcsd_pkg::WORD_W-1:0]   buf_ra_ff, buf_rb_ff;
   logic [rcsd_pkg::WIDE_W-1:0]   pa_ff, pb_ff, q_ff;
   logic [rcsd_pkg::WIDE_W-1:0]   x_ff, y_ff, room_ff, val_ff, r_ff;
   logic                          accept;
   logic                          mod_start;
   logic                          busy_a, busy_b;
   logic [rcsd_pkg::WORD_W-1:0]   ta, tb;
   logic                          live;

   assign live   = (cfg.modulus_a != '0) && (cfg.modulus_b != '0);
   assign accept = req_push && !buf_valid_ff;

   rcsd_modu u_mod_a (
      .clock(clock), .reset(reset), .start(mod_start), .dividend(pa_ff),
      .steps(rcsd_pkg::STEP_W'(rcsd_pkg::WIDE_W)), .modulus(cfg.modulus_a),
      .busy(busy_a), .result(ta)
   );

   rcsd_modu u_mod_b (
      .clock(clock), .reset(reset), .start(mod_start), .dividend(pb_ff),
      .steps(rcsd_pkg::STEP_W'(rcsd_pkg::WIDE_W)), .modulus(cfg.modulus_b),
      .busy(busy_b), .result(tb)
   );

   always_comb begin
      state_in     = state_ff;
      buf_valid_in = buf_valid_ff;
      mod_start    = 1'b0;
      q_push       = 1'b0;
      if (accept) buf_valid_in = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            if (buf_valid_ff) begin
               buf_valid_in = 1'b0;
               state_in     = ST_STRT;
            end
         end
         ST_STRT: begin
            mod_start = 1'b1;
            state_in  = ST_MODW;
         end
         ST_MODW: if (!busy_a && !busy_b) state_in = ST_PROD;
         ST_PROD: state_in = ST_ADD1;
         ST_ADD1: state_in = ST_ADD2;
         ST_ADD2: state_in = ST_CTR;
         ST_CTR:  state_in = ST_PUSH;
         ST_PUSH: begin
            q_push = !q_full;
            if (!q_full) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         buf_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         buf_valid_ff <= buf_valid_in;
      end
      if (accept) begin
         buf_ra_ff <= req_residue_a;
         buf_rb_ff <= req_residue_b;
      end
      // products before the serial reductions
      if (state_ff == ST_IDLE) begin
         pa_ff <= buf_ra_ff * cfg.inv_b_mod_a;
         pb_ff <= buf_rb_ff * cfg.inv_a_mod_b;
         q_ff  <= cfg.modulus_a * cfg.modulus_b;
      end
      if (state_ff == ST_PROD) begin
         x_ff <= ta * cfg.modulus_b;
         y_ff <= tb * cfg.modulus_a;
      end
      if (state_ff == ST_ADD1) room_ff <= q_ff - y_ff;
      if (state_ff == ST_ADD2) val_ff <= (x_ff >= room_ff) ? (x_ff - room_ff) : (x_ff + y_ff);
      if (state_ff == ST_CTR) begin
         if (!live)                       r_ff <= '0;
         else if (val_ff <= (q_ff >> 1))  r_ff <= val_ff;
         else                             r_ff <= val_ff - q_ff;
      end
   end

   assign req_full = buf_valid_ff;
   assign q_data   = r_ff;

endmodule

// File: rtl/rcsd_queue.sv
// two-entry queue of centered values between front and back
`timescale 1ns / 1ps
module rcsd_queue (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   input  logic [rcsd_pkg::WIDE_W-1:0]   push_data,
   output logic                          full,
   input  logic                          pop,
   output logic                          empty,
   output logic [rcsd_pkg::WIDE_W-1:0]   pop_data
);

   logic [rcsd_pkg::WIDE_W-1:0] mem_ff [2];
   logic                        wptr_ff, rptr_ff;
   logic [1:0]                  count_ff, count_in;
   logic                        do_push, do_pop;

   assign full    = (count_ff == 2'd2);
   assign empty   = (count_ff == 2'd0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) count_in = count_ff + 2'd1;
      if (!do_push && do_pop) count_in = count_ff - 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= 1'b0;
         rptr_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
         if (do_push) wptr_ff <= !wptr_ff;
         if (do_pop)  rptr_ff <= !rptr_ff;
      end
      if (do_push) mem_ff[wptr_ff] <= push_data;
   end

   assign pop_data = mem_ff[rptr_ff];

endmodule

// File: rtl/rcsd_back.sv
// back end: peels signed digits and reduces each into both residue rings
`timescale 1ns / 1ps
module rcsd_back (
   input  logic                          clock,
   input  logic                          reset,
   input  rcsd_pkg::cfg_type             cfg,
   input  logic                          q_empty,
   output logic                          q_pop,
   input  logic [rcsd_pkg::WIDE_W-1:0]   q_data,
   output logic                          rsp_empty,
   input  logic                          rsp_pop,
   output logic [rcsd_pkg::WORD_W-1:0]   rsp_digit_mod_a,
   output logic [rcsd_pkg::WORD_W-1:0]   rsp_digit_mod_b,
   output logic [rcsd_pkg::DNUM_W-1:0]   rsp_digit_number,
   output logic                          rsp_last_digit
);

   localparam int DB = rcsd_pkg::DIGIT_BITS;

   localparam logic [2:0] ST_LOAD = 3'd0;
   localparam logic [2:0] ST_PEEL = 3'd1;
   localparam logic [2:0] ST_STRT = 3'd2;
   localparam logic [2:0] ST_MODW = 3'd3;
   localparam logic [2:0] ST_EMIT = 3'd4;

   logic [2:0]                          state_ff, state_in;
   logic signed [rcsd_pkg::WIDE_W-1:0]  r_ff;
   logic signed [rcsd_pkg::WIDE_W-1:0]  r_in;
   logic [rcsd_pkg::DNUM_W-1:0]         j_ff, j_in;
   logic [DB-1:0]                       low, mag, mag_ff;
   logic                                neg, neg_ff;
   logic                                out_valid_ff, out_valid_in;
   logic                                mod_start, load_out, is_last;
   logic                                busy_a, busy_b;
   logic [rcsd_pkg::WORD_W-1:0]         ta, tb, da, db;
   logic [rcsd_pkg::WIDE_W-1:0]         dividend;
   logic                                live;

   assign live     = (cfg.modulus_a != '0) && (cfg.modulus_b != '0);
   assign low      = r_ff[DB-1:0];
   assign neg      = low[DB-1];
   assign mag      = neg ? DB'(-low) : low;
   // arithmetic shift by explicit sign fill, then round toward the next digit
   assign r_in     = {{DB{r_ff[rcsd_pkg::WIDE_W-1]}}, r_ff[rcsd_pkg::WIDE_W-1:DB]}
                     + rcsd_pkg::WIDE_W'(neg);
   assign dividend = rcsd_pkg::WIDE_W'(mag_ff) << (rcsd_pkg::WIDE_W - DB);
   assign is_last  = (j_ff == rcsd_pkg::DNUM_W'(rcsd_pkg::DIGITS - 1));

   rcsd_modu u_mod_a (
      .clock(clock), .reset(reset), .start(mod_start), .dividend(dividend),
      .steps(rcsd_pkg::STEP_W'(DB)), .modulus(cfg.modulus_a),
      .busy(busy_a), .result(ta)
   );

   rcsd_modu u_mod_b (
      .clock(clock), .reset(reset), .start(mod_start), .dividend(dividend),
      .steps(rcsd_pkg::STEP_W'(DB)), .modulus(cfg.modulus_b),
      .busy(busy_b), .result(tb)
   );

   // negative digit maps to q - t unless the remainder is zero
   assign da = (neg_ff && ta != '0) ? (cfg.modulus_a - ta) : ta;
   assign db = (neg_ff && tb != '0) ? (cfg.modulus_b - tb) : tb;

   always_comb begin
      state_in     = state_ff;
      j_in         = j_ff;
      q_pop        = 1'b0;
      mod_start    = 1'b0;
      load_out     = 1'b0;
      out_valid_in = out_valid_ff && !rsp_pop;
      case (state_ff)
         ST_LOAD: begin
            if (!q_empty) begin
               q_pop    = 1'b1;
               j_in     = '0;
               state_in = ST_PEEL;
            end
         end
         ST_PEEL: begin
            if (j_ff == '0) j_in = rcsd_pkg::DNUM_W'(1);
            else            state_in = ST_STRT;
         end
         ST_STRT: begin
            mod_start = 1'b1;
            state_in  = ST_MODW;
         end
         ST_MODW: if (!busy_a && !busy_b) state_in = ST_EMIT;
         ST_EMIT: begin
            if (!out_valid_ff || rsp_pop) begin
               load_out     = 1'b1;
               out_valid_in = 1'b1;
               if (is_last) begin
                  state_in = ST_LOAD;
               end else begin
                  j_in     = j_ff + 1'b1;
                  state_in = ST_PEEL;
               end
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         j_ff         <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         j_ff         <= j_in;
         out_valid_ff <= out_valid_in;
      end
      if (q_pop) r_ff <= q_data;
      if (state_ff == ST_PEEL) begin
         r_ff   <= r_in;
         mag_ff <= mag;
         neg_ff <= neg;
      end
      if (load_out) begin
         rsp_digit_mod_a  <= live ? da : '0;
         rsp_digit_mod_b  <= live ? db : '0;
         rsp_digit_number <= j_ff;
         rsp_last_digit   <= is_last;
      end
   end

   assign rsp_empty = !out_valid_ff;

endmodule

// File: rtl/rns_crt_signed_digit_decomposition_unit.sv
// top level of the rns crt signed digit decomposition unit
`timescale 1ns / 1ps
// the front lifts each accepted word with 64-step serial reductions, and the back
//   reduces each of its three digit words with 16-step ones
// the front reductions bound the coefficient rate; the input buffer takes the next
//   word while the front works, and the back emits digit words in overlap
// reset: synchronous active high; clears control state and loads the register
//   reset values (moduli 3 and 5, both inverses 2)
module rns_crt_signed_digit_decomposition_unit (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_push,
   output logic                             req_full,
   input  logic [rcsd_pkg::WORD_W-1:0]      req_residue_a,
   input  logic [rcsd_pkg::WORD_W-1:0]      req_residue_b,
   output logic                             rsp_empty,
   input  logic                             rsp_pop,
   output logic [rcsd_pkg::WORD_W-1:0]      rsp_digit_mod_a,
   output logic [rcsd_pkg::WORD_W-1:0]      rsp_digit_mod_b,
   output logic [rcsd_pkg::DNUM_W-1:0]      rsp_digit_number,
   output logic                             rsp_last_digit,
   input  logic                             csr_we,
   input  logic [rcsd_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [rcsd_pkg::WORD_W-1:0]      csr_wdata
);

   // configuration registers; the user keeps them static while words are in flight, the block does not enforce it
   rcsd_pkg::cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.modulus_a   <= rcsd_pkg::WORD_W'(3);
         cfg_ff.modulus_b   <= rcsd_pkg::WORD_W'(5);
         cfg_ff.inv_b_mod_a <= rcsd_pkg::WORD_W'(2);
         cfg_ff.inv_a_mod_b <= rcsd_pkg::WORD_W'(2);
      end else if (csr_we) begin
         case (csr_index)
            rcsd_pkg::CSR_MODULUS_A:   cfg_ff.modulus_a   <= csr_wdata;
            rcsd_pkg::CSR_MODULUS_B:   cfg_ff.modulus_b   <= csr_wdata;
            rcsd_pkg::CSR_INV_B_MOD_A: cfg_ff.inv_b_mod_a <= csr_wdata;
            rcsd_pkg::CSR_INV_A_MOD_B: cfg_ff.inv_a_mod_b <= csr_wdata;
            default: ;
         endcase
      end
   end

   // centered value handoff between front and back
   logic                          q_push, q_full, q_pop, q_empty;
   logic [rcsd_pkg::WIDE_W-1:0]   q_in_data, q_out_data;

   // front: crt lift and centering
   rcsd_front u_front (
      .clock(clock), .reset(reset), .cfg(cfg_ff),
      .req_push(req_push), .req_full(req_full),
      .req_residue_a(req_residue_a), .req_residue_b(req_residue_b),
      .q_push(q_push), .q_full(q_full), .q_data(q_in_data)
   );

   // short queue so the front keeps lifting while the back emits digits
   rcsd_queue u_queue (
      .clock(clock), .reset(reset),
      .push(q_push), .push_data(q_in_data), .full(q_full),
      .pop(q_pop), .empty(q_empty), .pop_data(q_out_data)
   );

   // back: digit peel and ring reduction, output register on the result side
   rcsd_back u_back (
      .clock(clock), .reset(reset), .cfg(cfg_ff),
      .q_empty(q_empty), .q_pop(q_pop), .q_data(q_out_data),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop),
      .rsp_digit_mod_a(rsp_digit_mod_a), .rsp_digit_mod_b(rsp_digit_mod_b),
      .rsp_digit_number(rsp_digit_number), .rsp_last_digit(rsp_last_digit)
   );

endmodule

// File: rtl/rcsd_checker.sv
// port-level checker for the rns crt signed digit decomposition unit
`timescale 1ns / 1ps
module rcsd_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_push,
   input logic                             req_full,
   input logic                             rsp_empty,
   input logic                             rsp_pop,
   input logic [rcsd_pkg::WORD_W-1:0]      rsp_digit_mod_a,
   input logic [rcsd_pkg::WORD_W-1:0]      rsp_digit_mod_b,
   input logic [rcsd_pkg::DNUM_W-1:0]      rsp_digit_number,
   input logic                             rsp_last_digit
);

   a_reset_idle: assert property (@(posedge clock) reset |=> (rsp_empty && !req_full))
      else $error("not idle after reset");

   a_accept_full: assert property (@(posedge clock) disable iff (reset)
      (req_push && !req_full) |=> req_full)
      else $error("input buffer not held after accept");

   a_number_range: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_digit_number != '0 &&
                      rsp_digit_number <= rcsd_pkg::DNUM_W'(rcsd_pkg::DIGITS - 1)))
      else $error("digit number out of range");

   a_last_flag: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_last_digit ==
                      (rsp_digit_number == rcsd_pkg::DNUM_W'(rcsd_pkg::DIGITS - 1))))
      else $error("last flag does not match digit number");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_digit_mod_a) &&
                                    $stable(rsp_digit_mod_b) && $stable(rsp_digit_number)))
      else $error("stalled word changed");

endmodule

bind rns_crt_signed_digit_decomposition_unit rcsd_checker u_chk (.*);
